// ===== rtl/spdc_pkg.sv =====
// Package for the segmented prime digit counter.
// Holds sizes, register indexes, reset values and shared types.
package spdc_pkg;
    localparam int VALUE_BITS = 20;
    localparam int MAX_SPAN   = 65536;
    localparam int BASE_LIMIT = 1024;
    localparam int SPAN_AW    = $clog2(MAX_SPAN);
    localparam int BASE_AW    = $clog2(BASE_LIMIT);
    localparam int SPAN_CW    = SPAN_AW + 1;
    localparam int COUNT_W    = 17;
    localparam int DIGIT_W    = 4;
    localparam int MATCH_W    = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DIGIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MATCHES  = 1'd1;

    localparam logic [DIGIT_W-1:0] TARGET_RESET = 4'd3;
    localparam logic [MATCH_W-1:0] MIN_RESET    = 3'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = {COUNT_W{1'b1}};

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [DIGIT_W-1:0]    digit_t;
endpackage

// ===== rtl/spdc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module spdc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/spdc_digits.sv =====
// Digit matcher: splits a value into decimal digits, one per cycle.
// Depends on spdc_pkg.
module spdc_digits (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  spdc_pkg::value_t      value,
    input  spdc_pkg::digit_t      target,
    output logic                  busy,
    output logic [2:0]            hits
);
    import spdc_pkg::*;

    value_t     rem_reg, rem_next;
    logic [2:0] hits_reg, hits_next;
    logic       busy_reg, busy_next;
    value_t     quot;
    logic [3:0] dig;
    logic [VALUE_BITS+24:0] prod;

    // Divide by ten through a reciprocal with one correction step
    always_comb
    begin
        prod = ({25'd0, rem_reg} * 45'd3355444) >> 25;
        quot = prod[VALUE_BITS-1:0];
        if ((rem_reg - quot * value_t'(10)) >= value_t'(10))
        begin
            quot = quot + value_t'(1);
        end
        dig = 4'(rem_reg - quot * value_t'(10));
    end

    // Strip one digit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        hits_next = hits_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = value;
            hits_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                rem_next = quot;
                if (dig == target && hits_reg != 3'd7)
                begin
                    hits_next = hits_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        hits_reg <= hits_next;
    end

    assign busy = busy_reg;
    assign hits = hits_reg;
endmodule

// ===== rtl/segmented_prime_digit_counter.sv =====
// Segmented prime digit counter, top level.
// Request: range_start/range_end (valid/ready). Result: match_count and
// range_error (valid/ready). Config: cfg_we/cfg_idx/cfg_data.
// One request is processed at a time. Phases, one memory access per cycle:
// root search, base fill, base sieve (a read and a check per candidate plus,
// for each prime, one write per marked multiple), segment fill, segment sieve
// (a read and a check per candidate plus, for each base prime, a division step
// per bit for the first multiple and one write per struck multiple), and scan
// (a read and a check per value plus digit stripping for each prime). A
// rejected request goes from the root search straight to the result state.
// The result waits in its output register until taken; ready for a new
// request returns only once the result has been delivered. Reset clears the
// sequencer and restores target_digit 3 and min_matches 2; memories need
// no clearing since each request writes every entry it reads.
module segmented_prime_digit_counter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  spdc_pkg::value_t                  range_start,
    input  spdc_pkg::value_t                  range_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [spdc_pkg::COUNT_W-1:0]      match_count,
    output logic                              range_error,
    input  logic                              cfg_we,
    input  logic [spdc_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [spdc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spdc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ROOT  = 4'd1;
    localparam logic [3:0] S_BFILL = 4'd2;
    localparam logic [3:0] S_BRD   = 4'd3;
    localparam logic [3:0] S_BCHK  = 4'd4;
    localparam logic [3:0] S_BSTR  = 4'd5;
    localparam logic [3:0] S_SFILL = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PCHK  = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_SSTR  = 4'd10;
    localparam logic [3:0] S_CRD   = 4'd11;
    localparam logic [3:0] S_CCHK  = 4'd12;
    localparam logic [3:0] S_CDIG  = 4'd13;
    localparam logic [3:0] S_OUT   = 4'd14;

    logic [3:0]         state_reg, state_next;
    digit_t             tgt_reg;
    logic [MATCH_W-1:0] minm_reg;
    value_t             a_reg, a_next, b_reg, b_next;
    logic [BASE_AW:0]   root_reg, root_next;
    logic [BASE_AW:0]   p_reg, p_next;
    logic [BASE_AW:0]   j_reg, j_next;
    logic [VALUE_BITS:0] sj_reg, sj_next;
    logic [SPAN_CW-1:0] i_reg, i_next;
    logic [SPAN_CW-1:0] len_reg, len_next;
    value_t             rem_reg, rem_next;
    logic [4:0]         dbit_reg, dbit_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               err_reg, err_next;

    // Base memory port
    logic               bwe;
    logic [BASE_AW-1:0] baddr;
    logic               bwd, brd;
    // Segment memory port
    logic               swe;
    logic [SPAN_AW-1:0] saddr;
    logic               swd, srd;
    // Digit unit
    logic               dstart, dbusy;
    logic [2:0]         dhits;

    logic [2*(BASE_AW+1)-1:0] rsq, psq;
    logic [VALUE_BITS:0]      span;
    logic [VALUE_BITS+1:0]    trial;
    logic [VALUE_BITS:0]      first;

    spdc_ram #(.WIDTH(1), .DEPTH(BASE_LIMIT)) u_base (
        .clk(clk), .we(bwe), .addr(baddr), .wdata(bwd), .rdata(brd)
    );
    spdc_ram #(.WIDTH(1), .DEPTH(MAX_SPAN)) u_seg (
        .clk(clk), .we(swe), .addr(saddr), .wdata(swd), .rdata(srd)
    );
    spdc_digits u_dig (
        .clk(clk), .rst_n(rst_n), .start(dstart),
        .value(value_t'(a_reg + value_t'(i_reg))),
        .target(tgt_reg), .busy(dbusy), .hits(dhits)
    );

    always_comb
    begin
        rsq   = (root_reg + 1'b1) * (root_reg + 1'b1);
        psq   = p_reg * p_reg;
        span  = {1'b0, b_reg} - {1'b0, a_reg} + 1'b1;
        trial = {1'b0, rem_reg, 1'b0} + {21'd0, a_reg[dbit_reg]}
                - {{(VALUE_BITS+1-BASE_AW){1'b0}}, p_reg};
        // First multiple at or above a: a - (a mod p) rounded up
        first = (rem_reg == '0) ? {1'b0, a_reg}
                : {1'b0, a_reg} + {{(VALUE_BITS-BASE_AW){1'b0}}, p_reg}
                  - {1'b0, rem_reg};
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        a_next = a_reg; b_next = b_reg; root_next = root_reg;
        p_next = p_reg; j_next = j_reg; sj_next = sj_reg;
        i_next = i_reg; len_next = len_reg; rem_next = rem_reg;
        dbit_next = dbit_reg; cnt_next = cnt_reg;
        err_next = err_reg;
        bwe = 1'b0; baddr = j_reg[BASE_AW-1:0]; bwd = 1'b0;
        swe = 1'b0; saddr = i_reg[SPAN_AW-1:0]; swd = 1'b0;
        dstart = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next = range_start;
                    b_next = range_end;
                    root_next = '0;
                    cnt_next = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                // Reject a bad range, else step the root up until (r+1)^2 exceeds b
                if (span > (VALUE_BITS+1)'(MAX_SPAN) || a_reg < value_t'(2)
                    || b_reg < a_reg || root_reg >= (BASE_AW+1)'(BASE_LIMIT))
                begin
                    err_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (rsq <= {2'b00, b_reg})
                begin
                    root_next = root_reg + 1'b1;
                end
                else
                begin
                    err_next = 1'b0;
                    j_next = '0;
                    state_next = S_BFILL;
                end
            end
            S_BFILL:
            begin
                bwe = 1'b1;
                bwd = (j_reg >= (BASE_AW+1)'(2));
                if (j_reg == root_reg)
                begin
                    p_next = (BASE_AW+1)'(2);
                    state_next = S_BRD;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_BRD:
            begin
                baddr = p_reg[BASE_AW-1:0];
                if ({{(BASE_AW+1){1'b0}}, root_reg} < psq)
                begin
                    i_next = '0;
                    len_next = span[SPAN_CW-1:0];
                    state_next = S_SFILL;
                end
                else
                begin
                    state_next = S_BCHK;
                end
            end
            S_BCHK:
            begin
                j_next = psq[BASE_AW:0];
                if (brd)
                begin
                    state_next = S_BSTR;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_BRD;
                end
            end
            S_BSTR:
            begin
                if (j_reg > root_reg)
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_BRD;
                end
                else
                begin
                    bwe = 1'b1;
                    j_next = j_reg + p_reg;
                end
            end
            S_SFILL:
            begin
                swe = 1'b1;
                swd = 1'b1;
                if (i_reg == len_reg - 1'b1)
                begin
                    p_next = (BASE_AW+1)'(2);
                    state_next = S_PRD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_PRD:
            begin
                baddr = p_reg[BASE_AW-1:0];
                if (p_reg > root_reg)
                begin
                    i_next = '0;
                    state_next = S_CRD;
                end
                else
                begin
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                rem_next = '0;
                dbit_next = 5'(VALUE_BITS-1);
                if (brd)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_PRD;
                end
            end
            S_DIV:
            begin
                // Restoring division of a by p, one bit per cycle (remainder)
                if (!trial[VALUE_BITS+1])
                begin
                    rem_next = trial[VALUE_BITS-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[VALUE_BITS-2:0], a_reg[dbit_reg]};
                end
                if (dbit_reg == 5'd0)
                begin
                    state_next = S_SSTR;
                end
                else
                begin
                    dbit_next = dbit_reg - 5'd1;
                end
                sj_next = '0;
            end
            S_SSTR:
            begin
                if (sj_reg == '0)
                begin
                    sj_next = (first < psq[VALUE_BITS:0]) ? psq[VALUE_BITS:0] : first;
                    if (sj_next == '0)
                    begin
                        sj_next = {{VALUE_BITS{1'b0}}, 1'b1} << VALUE_BITS;
                    end
                end
                else if (sj_reg > {1'b0, b_reg})
                begin
                    p_next = p_reg + 1'b1;
                    state_next = S_PRD;
                end
                else
                begin
                    swe = 1'b1;
                    saddr = SPAN_AW'(sj_reg - {1'b0, a_reg});
                    sj_next = sj_reg + {{(VALUE_BITS-BASE_AW){1'b0}}, p_reg};
                end
            end
            S_CRD:
            begin
                if (i_reg == len_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CCHK;
                end
            end
            S_CCHK:
            begin
                if (srd)
                begin
                    dstart = 1'b1;
                    state_next = S_CDIG;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_CDIG:
            begin
                if (!dbusy)
                begin
                    if (dhits >= minm_reg && cnt_reg != COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tgt_reg   <= TARGET_RESET;
            minm_reg  <= MIN_RESET;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
            if (cfg_we && cfg_idx == REG_TARGET_DIGIT)
            begin
                tgt_reg <= cfg_data;
            end
            if (cfg_we && cfg_idx == REG_MIN_MATCHES)
            begin
                minm_reg <= cfg_data[MATCH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; b_reg <= b_next; root_reg <= root_next;
        p_reg <= p_next; j_reg <= j_next; sj_reg <= sj_next;
        i_reg <= i_next; len_reg <= len_next; rem_reg <= rem_next;
        dbit_reg <= dbit_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign match_count = err_reg ? '0 : cnt_reg;
    assign range_error = err_reg;

    // Result never claims both an error and a count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> match_count == '0)
        else $error("error result with nonzero count");
    // Request and result sides never open together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request and result both open");
    // Count holds while result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(match_count))
        else $error("result changed while stalled");
endmodule

// ===== tb/segmented_prime_digit_counter_tb.sv =====
// Testbench for the segmented prime digit counter.
// Drives range requests and register writes, predicts each count with its own
// sieve, and checks every result in order. Depends on rtl/spdc_pkg.sv and the top level.
module segmented_prime_digit_counter_tb;
    import spdc_pkg::*;

    localparam int WATCH_LIMIT = 2000000;

    typedef struct packed {
        logic [16:0] count;
        logic        err;
    } tally_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    value_t      range_start;
    value_t      range_end;
    logic        out_valid;
    logic        out_ready;
    logic [16:0] match_count;
    logic        range_error;
    logic        cfg_we;
    logic [0:0]  cfg_idx;
    logic [3:0]  cfg_data;

    // model copies of the registers
    logic [3:0]  want_digit;
    logic [2:0]  want_min;
    tally_t      pending_tallies[$];
    int          mismatches;
    int          idle_cycles;
    bit          prime_flag[];
    int          seg_flag[];

    segmented_prime_digit_counter i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .range_start(range_start), .range_end(range_end),
        .out_valid(out_valid), .out_ready(out_ready),
        .match_count(match_count), .range_error(range_error),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // count primes in [lo, hi] that carry enough target digits
    function automatic tally_t count_digit_primes(int lo, int hi);
        tally_t t;
        int root;
        int v;
        int hits;
        int first;
        t.count = '0;
        t.err = 1'b0;
        root = 0;
        while ((root + 1) * (root + 1) <= hi)
            root++;
        if (lo < 2 || hi < lo || (hi - lo + 1) > MAX_SPAN || root >= BASE_LIMIT) begin
            t.err = 1'b1;
            return t;
        end
        seg_flag = new[hi - lo + 1];
        foreach (seg_flag[i])
            seg_flag[i] = 1;
        for (int p = 2; p <= root; p++) begin
            if (prime_flag[p]) begin
                first = ((lo + p - 1) / p) * p;
                if (first < p * p)
                    first = p * p;
                for (int j = first; j <= hi; j += p)
                    seg_flag[j - lo] = 0;
            end
        end
        for (int i = 0; i <= hi - lo; i++) begin
            if (seg_flag[i] != 0) begin
                v = lo + i;
                hits = 0;
                while (v != 0) begin
                    if (v % 10 == want_digit)
                        hits++;
                    v /= 10;
                end
                if (hits >= want_min && t.count != COUNT_MAX)
                    t.count++;
            end
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, exp_val);
        mismatches++;
    endtask

    // send one range request after a random gap; drop the previous,
    // already accepted, request only when a gap follows it
    task automatic send_range(input int lo, input int hi);
        int gap;
        gap = $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pending_tallies.push_back(count_digit_primes(lo, hi));
        range_start <= value_t'(lo);
        range_end <= value_t'(hi);
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop the request line and hold until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_tallies.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [3:0] val);
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == REG_TARGET_DIGIT)
            want_digit = val;
        else
            want_min = val[2:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls, compare with the oldest prediction
    initial
    begin
        tally_t exp_t;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(0, 17)) @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            if (pending_tallies.size() == 0) begin
                report_mismatch("result with no request outstanding", 1, 0);
            end else begin
                exp_t = pending_tallies.pop_front();
                if (match_count !== exp_t.count)
                    report_mismatch("match_count", match_count, exp_t.count);
                if (range_error !== exp_t.err)
                    report_mismatch("range_error", range_error, exp_t.err);
            end
            @(negedge clk);
            out_ready <= 1'b0;
        end
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("segmented_prime_digit_counter_tb failed");
            $finish;
        end
    end

    task automatic test_bad_ranges();
        send_range(0, 10);
        send_range(1, 1);
        send_range(50, 49);
        send_range(2, 65538);
        send_range(1048575, 0);
        send_range(1048575 - MAX_SPAN, 1048575);
    endtask

    task automatic test_edges();
        send_range(2, 2);
        send_range(2, 3);
        send_range(4, 4);
        send_range(2, 1000);
        send_range(1048575, 1048575);
        send_range(1048500, 1048575);
        send_range(2, 65537);
        send_range(333300, 333400);
        send_range(1048575 - MAX_SPAN + 1, 1048575);
        send_range(961, 961);
        send_range(1021 * 1021 - 5, 1021 * 1021 + 5);
    endtask

    task automatic test_registers();
        write_reg(REG_MIN_MATCHES, 4'd0);
        send_range(2, 500);
        write_reg(REG_TARGET_DIGIT, 4'd15);
        send_range(100, 400);
        write_reg(REG_MIN_MATCHES, 4'd1);
        send_range(100, 400);
        write_reg(REG_TARGET_DIGIT, 4'd0);
        send_range(100000, 101000);
        write_reg(REG_MIN_MATCHES, 4'd7);
        send_range(2, 3000);
        wait_drained();
    endtask

    // mostly small valid ranges, a few large ones and some bad ones
    task automatic test_random();
        int lo;
        int span;
        for (int n = 0; n < 100; n++) begin
            if (n % 20 == 0) begin
                wait_drained();
                write_reg(REG_TARGET_DIGIT, 4'($urandom_range(0, 15)));
                write_reg(REG_MIN_MATCHES, 3'($urandom_range(0, 7)));
            end
            lo = $urandom_range(0, 1048575);
            case ($urandom_range(0, 9))
                0: span = $urandom_range(60000, 65536);
                1: span = $urandom_range(65537, 200000);
                2: span = -$urandom_range(0, 100);
                default: span = $urandom_range(1, 800);
            endcase
            if (span > 0 && lo + span - 1 > 1048575)
                lo = 1048576 - span;
            send_range(lo, (lo + span - 1) & 20'hfffff);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        range_start = '0;
        range_end = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        want_digit = TARGET_RESET;
        want_min = MIN_RESET;
        // base primes up to the largest root
        prime_flag = new[BASE_LIMIT];
        foreach (prime_flag[i])
            prime_flag[i] = (i >= 2);
        for (int p = 2; p * p < BASE_LIMIT; p++)
            if (prime_flag[p])
                for (int j = p * p; j < BASE_LIMIT; j += p)
                    prime_flag[j] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        test_bad_ranges();
        test_edges();
        wait_drained();
        test_registers();
        test_random();
        wait_drained();
        if (mismatches == 0)
            $display("segmented_prime_digit_counter_tb passed");
        else
            $display("segmented_prime_digit_counter_tb failed");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/spdc_pkg.sv
rtl/spdc_ram.sv
rtl/spdc_digits.sv
rtl/segmented_prime_digit_counter.sv
tb/segmented_prime_digit_counter_tb.sv
